FILE: rtl/efb_pkg.sv
// ----------------------------------------------------------------------------
// Escaped frame builder package
// Byte-stuffing constants, register indexes and the special-byte test.
// ----------------------------------------------------------------------------
package efb_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned LenW     = 16;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [ByteW-1:0] EscByte    = 8'h10;
  localparam logic [ByteW-1:0] EscOffset  = 8'h20;
  localparam logic [ByteW-1:0] StartReset = 8'h01;
  localparam logic [ByteW-1:0] EndReset   = 8'h04;

  localparam logic [CfgIdxW-1:0] RegStartByte = 1'b0;
  localparam logic [CfgIdxW-1:0] RegEndByte   = 1'b1;

  localparam logic ReqStart = 1'b0;
  localparam logic ReqData  = 1'b1;

  // True for the bytes that must travel as an escape pair.
  function automatic logic is_special(input logic [ByteW-1:0] b);
    is_special = (b == 8'h01) || (b == 8'h04) || (b == 8'h10) ||
                 (b == 8'h11) || (b == 8'h13);
  endfunction

endpackage

FILE: rtl/escaped_frame_builder.sv
// ----------------------------------------------------------------------------
// Escaped frame builder
// Turns start and payload words into a byte-stuffed frame with an additive
// checksum and configurable start and end delimiters.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Signals                              | Content
//  s_axis   | in        | tvalid tready tdata[47:0] tuser      | header or payload word
//  m_axis   | out       | tvalid tready tdata[7:0] tlast tuser | one frame byte
//  cfg      | in        | cfg_valid_i cfg_ready_o idx data     | delimiter registers
//
// One output byte leaves per cycle while m_axis is ready. A payload word
// gives one byte, two when it is escaped, plus two or three for the trailer;
// a start word gives six to twelve bytes. The byte sequencer paces input: the
// next input word is taken in the cycle its predecessor's last byte enters
// the output register. Reset clears the frame state and the delimiters to
// 0x01 and 0x04. A stall on m_axis holds the output register and the sequencer.
module escaped_frame_builder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input words
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // command[7:0], version_byte[15:8], sequence_number[23:16],
  // payload_length[39:24], payload_byte[47:40]
  input  logic [efb_pkg::InDataW-1:0]         s_axis_tdata,
  // req_type[0]
  input  logic                                s_axis_tuser,
  // Output bytes
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // out_byte[7:0]
  output logic [efb_pkg::ByteW-1:0]           m_axis_tdata,
  output logic                                m_axis_tlast,
  // frame_end[0]
  output logic                                m_axis_tuser,
  // Configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [efb_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [efb_pkg::ByteW-1:0]           cfg_data_i
);

  typedef enum logic [3:0] {
    PhStart, PhCmd, PhVer, PhSeq, PhLenHi, PhLenLo, PhData, PhSum, PhEnd
  } phase_e;

  logic [efb_pkg::ByteW-1:0] start_byte_q, end_byte_q;
  logic                      in_frame_q;
  logic [efb_pkg::LenW-1:0]  bytes_left_q;
  logic [efb_pkg::ByteW-1:0] sum_q, sum_d;

  logic                      busy_q;
  phase_e                    phase_q, phase_d;
  logic                      esc_q, esc_d;
  logic                      trailer_q;

  logic [efb_pkg::ByteW-1:0] cmd_q, ver_q, seq_q, pay_q;
  logic [efb_pkg::LenW-1:0]  len_q;

  logic                      out_valid_q, out_last_q, out_end_q;
  logic [efb_pkg::ByteW-1:0] out_data_q;

  logic                      emit_en, emit_last, emit_end, emit_add;
  logic [efb_pkg::ByteW-1:0] emit_byte, stuff_val;
  logic                      in_acc, in_start, opens_work;
  logic [efb_pkg::LenW-1:0]  in_len, left_dec;

  assign cfg_ready_o = 1'b1;

  assign emit_en       = busy_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !busy_q || (emit_en && emit_last);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_start      = (s_axis_tuser == efb_pkg::ReqStart);
  assign in_len        = s_axis_tdata[39:24];
  assign left_dec      = bytes_left_q - 16'd1;
  // Payload words outside a frame are taken and dropped.
  assign opens_work    = in_start || in_frame_q;

  // Value that the current stuffed phase sends.
  always_comb begin
    case (phase_q)
      PhSeq:   stuff_val = seq_q;
      PhLenHi: stuff_val = len_q[15:8];
      PhLenLo: stuff_val = len_q[7:0];
      PhData:  stuff_val = pay_q;
      default: stuff_val = sum_q;
    endcase
  end

  // Byte sequencer: picks the next byte and the phase after it.
  always_comb begin
    emit_byte = stuff_val;
    emit_last = 1'b0;
    emit_end  = 1'b0;
    emit_add  = 1'b1;
    phase_d   = phase_q;
    esc_d     = 1'b0;
    unique case (phase_q)
      PhStart: begin
        emit_byte = start_byte_q;
        emit_add  = 1'b0;
        phase_d   = PhCmd;
      end
      PhCmd: begin
        emit_byte = cmd_q;
        phase_d   = PhVer;
      end
      PhVer: begin
        emit_byte = ver_q;
        phase_d   = PhSeq;
      end
      PhSeq, PhLenHi, PhLenLo, PhData, PhSum: begin
        emit_add = (phase_q != PhSum);
        if (!esc_q && efb_pkg::is_special(stuff_val)) begin
          emit_byte = efb_pkg::EscByte;
          esc_d     = 1'b1;
        end else begin
          if (esc_q) begin
            emit_byte = stuff_val + efb_pkg::EscOffset;
          end
          unique case (phase_q)
            PhSeq:   phase_d = PhLenHi;
            PhLenHi: phase_d = PhLenLo;
            PhSum:   phase_d = PhEnd;
            default: begin
              if (trailer_q) begin
                phase_d = PhSum;
              end else begin
                emit_last = 1'b1;
              end
            end
          endcase
        end
      end
      PhEnd: begin
        emit_byte = end_byte_q;
        emit_add  = 1'b0;
        emit_end  = 1'b1;
        emit_last = 1'b1;
      end
      default: begin
        emit_last = 1'b1;
      end
    endcase
  end

  always_comb begin
    sum_d = sum_q;
    if (emit_en) begin
      if (phase_q == PhStart) begin
        sum_d = '0;
      end else if (emit_add) begin
        sum_d = sum_q + emit_byte;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= efb_pkg::StartReset;
      end_byte_q   <= efb_pkg::EndReset;
      in_frame_q   <= 1'b0;
      bytes_left_q <= '0;
      sum_q        <= '0;
      busy_q       <= 1'b0;
      phase_q      <= PhStart;
      esc_q        <= 1'b0;
      trailer_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      out_last_q   <= 1'b0;
      out_end_q    <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          efb_pkg::RegStartByte: start_byte_q <= cfg_data_i;
          default:               end_byte_q   <= cfg_data_i;
        endcase
      end

      sum_q <= sum_d;

      if (emit_en) begin
        out_valid_q <= 1'b1;
        out_last_q  <= emit_last;
        out_end_q   <= emit_end;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      // Frame bookkeeping runs at acceptance, ahead of the bytes it causes.
      if (in_acc && opens_work) begin
        busy_q <= 1'b1;
        esc_q  <= 1'b0;
        if (in_start) begin
          phase_q      <= PhStart;
          bytes_left_q <= in_len;
          in_frame_q   <= (in_len != '0);
          trailer_q    <= (in_len == '0);
        end else begin
          phase_q      <= PhData;
          bytes_left_q <= left_dec;
          in_frame_q   <= (left_dec != '0);
          trailer_q    <= (left_dec == '0);
        end
      end else if (emit_en) begin
        phase_q <= phase_d;
        esc_q   <= esc_d;
        if (emit_last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_en) begin
      out_data_q <= emit_byte;
    end
    if (in_acc) begin
      cmd_q <= s_axis_tdata[7:0];
      ver_q <= s_axis_tdata[15:8];
      seq_q <= s_axis_tdata[23:16];
      len_q <= in_len;
      pay_q <= s_axis_tdata[47:40];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_end_q;

  // The end delimiter always closes the run of its word.
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (!m_axis_tuser || m_axis_tlast))
    else $error("end delimiter without tlast");

  // A new word is only taken while busy when the last byte is leaving.
  a_ready_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && s_axis_tready) |-> (emit_en && emit_last))
    else $error("input taken mid-run");

  // The escape half only exists in a stuffed phase.
  a_esc_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_q |-> (phase_q == PhSeq || phase_q == PhLenHi || phase_q == PhLenLo ||
               phase_q == PhData || phase_q == PhSum))
    else $error("escape pending in an unstuffed phase");

endmodule

FILE: dv/escaped_frame_builder_tb.sv
// ----------------------------------------------------------------------------
// Escaped frame builder testbench
// Sends start and payload words with random bursts and gaps. It predicts
// the stuffed frame bytes, with checksum and delimiters, for every accepted
// word, and checks each output byte against them under receiver stalls and
// several delimiter settings.
// ----------------------------------------------------------------------------
module escaped_frame_builder_tb;

  localparam int unsigned IdleLimit    = 2000;
  localparam int unsigned SettleCycles = 24;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned PhaseWords   = 64;

  typedef struct packed {
    logic                      req;
    logic [efb_pkg::ByteW-1:0] cmd;
    logic [efb_pkg::ByteW-1:0] ver;
    logic [efb_pkg::ByteW-1:0] seq;
    logic [efb_pkg::LenW-1:0]  len;
    logic [efb_pkg::ByteW-1:0] pay;
  } frame_word_t;

  typedef struct packed {
    logic [efb_pkg::ByteW-1:0] data;
    logic                      last;
    logic                      fend;
  } frame_byte_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [efb_pkg::InDataW-1:0]  s_axis_tdata = '0;
  logic                         s_axis_tuser = 1'b0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [efb_pkg::ByteW-1:0]    m_axis_tdata;
  logic                         m_axis_tlast;
  logic                         m_axis_tuser;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [efb_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [efb_pkg::ByteW-1:0]    cfg_data_i = '0;

  frame_word_t word_q[$];
  frame_byte_t expected_bytes_q[$];

  // Predictor copy of the block's state and delimiters.
  bit                        frame_open;
  logic [efb_pkg::LenW-1:0]  payload_left;
  logic [efb_pkg::ByteW-1:0] frame_sum;
  logic [efb_pkg::ByteW-1:0] start_delim;
  logic [efb_pkg::ByteW-1:0] end_delim;

  int unsigned err_cnt;
  int unsigned bytes_checked;
  int unsigned starts_sent;
  int unsigned payloads_sent;
  int unsigned delim_writes;
  int unsigned idle_cycles;
  int unsigned hold_req_cnt;
  int unsigned hold_taken;
  int unsigned hold_left;
  int unsigned pace_mode;
  int unsigned pace_left;
  int unsigned pace_phase;
  int unsigned burst_left;
  int unsigned gap_left;

  escaped_frame_builder DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Frame predictor
  // ---------------------------------------------------------------------------
  function automatic bit needs_escape(input logic [efb_pkg::ByteW-1:0] b);
    case (b)
      8'h01, 8'h04, 8'h10, 8'h11, 8'h13: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void emit_byte(input logic [efb_pkg::ByteW-1:0] b, input bit fend,
                                    input bit summed);
    frame_byte_t e;
    e.data = b;
    e.last = 1'b0;
    e.fend = fend;
    expected_bytes_q.push_back(e);
    if (summed) frame_sum = frame_sum + b;
  endfunction

  function automatic void emit_stuffed(input logic [efb_pkg::ByteW-1:0] b,
                                       input bit summed);
    if (needs_escape(b)) begin
      emit_byte(efb_pkg::EscByte, 1'b0, summed);
      emit_byte(b + efb_pkg::EscOffset, 1'b0, summed);
    end else begin
      emit_byte(b, 1'b0, summed);
    end
  endfunction

  function automatic void emit_trailer();
    logic [efb_pkg::ByteW-1:0] sum;
    sum = frame_sum;
    emit_stuffed(sum, 1'b0);
    emit_byte(end_delim, 1'b1, 1'b0);
    frame_open = 1'b0;
  endfunction

  // Appends the bytes one accepted word must cause, marking the last of them.
  function automatic void predict_frame_bytes(input frame_word_t w);
    int unsigned n0;
    n0 = expected_bytes_q.size();
    if (w.req == efb_pkg::ReqStart) begin
      frame_sum = '0;
      frame_open = 1'b1;
      payload_left = w.len;
      emit_byte(start_delim, 1'b0, 1'b0);
      emit_byte(w.cmd, 1'b0, 1'b1);
      emit_byte(w.ver, 1'b0, 1'b1);
      emit_stuffed(w.seq, 1'b1);
      emit_stuffed(w.len[15:8], 1'b1);
      emit_stuffed(w.len[7:0], 1'b1);
      if (payload_left == '0) emit_trailer();
    end else if (frame_open) begin
      emit_stuffed(w.pay, 1'b1);
      payload_left = payload_left - 1'b1;
      if (payload_left == '0) emit_trailer();
    end
    if (expected_bytes_q.size() > n0)
      expected_bytes_q[expected_bytes_q.size()-1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [efb_pkg::ByteW-1:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'h01;
      1: return 8'h04;
      2: return 8'h10;
      3: return 8'h11;
      4: return 8'h13;
      5: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  // Unused fields carry random filler so that every bit toggles.
  function automatic void push_start(input logic [efb_pkg::ByteW-1:0] cmd,
                                     input logic [efb_pkg::ByteW-1:0] ver,
                                     input logic [efb_pkg::ByteW-1:0] seq,
                                     input logic [efb_pkg::LenW-1:0] len);
    frame_word_t w;
    w.req = efb_pkg::ReqStart;
    w.cmd = cmd;
    w.ver = ver;
    w.seq = seq;
    w.len = len;
    w.pay = 8'($urandom);
    word_q.push_back(w);
  endfunction

  function automatic void push_payload(input logic [efb_pkg::ByteW-1:0] pay);
    frame_word_t w;
    w = frame_word_t'({$urandom, $urandom});
    w.req = efb_pkg::ReqData;
    w.pay = pay;
    word_q.push_back(w);
  endfunction

  // Mostly complete frames; some abandoned ones with lengths of 6 to 65535 and a
  // few stray payload words between frames.
  function automatic void queue_random_frames(input int unsigned target);
    int unsigned counted;
    int unsigned kind;
    int unsigned len;
    int unsigned sent;
    counted = 0;
    while (counted < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 70)      len = $urandom_range(0, 9);
      else if (kind < 82) len = $urandom_range(10, 40);
      else if (kind < 90) len = 0;
      else                len = $urandom_range(6, 65535);
      push_start(pick_byte(), pick_byte(), pick_byte(), len[efb_pkg::LenW-1:0]);
      counted++;
      if (kind >= 90) begin
        sent = $urandom_range(0, 5);
      end else begin
        sent = len;
      end
      for (int unsigned i = 0; i < sent; i++) begin
        push_payload(pick_byte());
        counted++;
      end
      if (kind < 90 && $urandom_range(0, 9) == 0) push_payload(pick_byte());
    end
  endfunction

  task automatic write_delimiter(input logic [efb_pkg::CfgIdxW-1:0] idx,
                                 input logic [efb_pkg::ByteW-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == efb_pkg::RegStartByte) start_delim = value;
    else end_delim = value;
    delim_writes++;
  endtask

  // Waits until every queued word is taken and every predicted byte has come.
  task automatic drain();
    do @(posedge clk_i); while (word_q.size() != 0 || expected_bytes_q.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at byte %0d: %s", bytes_checked, msg);
    err_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // Word driver: bursts of random length with random gaps.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : word_drive
    frame_word_t w;
    bit busy;
    busy = s_axis_tvalid;
    if (s_axis_tvalid && s_axis_tready) begin
      w = word_q.pop_front();
      predict_frame_bytes(w);
      if (w.req == efb_pkg::ReqStart) starts_sent++;
      else payloads_sent++;
      busy = 1'b0;
    end
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (busy) begin
      // The offered word is held until it is taken.
    end else if (gap_left > 0) begin
      gap_left--;
      s_axis_tvalid <= 1'b0;
    end else if (word_q.size() != 0) begin
      w = word_q[0];
      s_axis_tdata  <= {w.pay, w.len, w.seq, w.ver, w.cmd};
      s_axis_tuser  <= w.req;
      s_axis_tvalid <= 1'b1;
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 24);
        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver pacing, with one long hold-off on request.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : byte_pace
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_req_cnt != hold_taken) begin
      hold_taken = hold_req_cnt;
      hold_left  = HoldCycles;
      m_axis_tready <= 1'b0;
    end else begin
      if (pace_left == 0) begin
        pace_mode = $urandom_range(0, 3);
        pace_left = $urandom_range(16, 96);
      end
      pace_left--;
      pace_phase++;
      case (pace_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        2: m_axis_tready <= ((pace_phase % 7) < 4);
        default: m_axis_tready <= ($urandom_range(0, 2) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Output byte checker
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : byte_check
    frame_byte_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_bytes_q.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h", m_axis_tdata));
      end else begin
        want = expected_bytes_q.pop_front();
        if (m_axis_tdata !== want.data)
          report_mismatch($sformatf("out_byte %02h, expected %02h", m_axis_tdata, want.data));
        if (m_axis_tlast !== want.last)
          report_mismatch($sformatf("run_last %b, expected %b", m_axis_tlast, want.last));
        if (m_axis_tuser !== want.fend)
          report_mismatch($sformatf("frame_end %b, expected %b", m_axis_tuser, want.fend));
      end
      bytes_checked++;
    end
  end

  // Ends the run when nothing moves on any channel for too long.
  always @(posedge clk_i) begin : watchdog
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Timeout: no word moved for %0d cycles", IdleLimit);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence of phases
  // ---------------------------------------------------------------------------
  initial begin
    frame_open   = 1'b0;
    payload_left = '0;
    frame_sum    = '0;
    start_delim  = efb_pkg::StartReset;
    end_delim    = efb_pkg::EndReset;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under the reset delimiters.
    push_payload(8'h55);                        // no frame open: ignored
    push_start(8'h01, 8'h00, 8'h00, 16'h0000);  // checksum 0x01 needs escaping
    push_start(8'hFF, 8'hFF, 8'hFF, 16'h0000);
    push_start(8'h10, 8'h13, 8'h11, 16'h0104);  // both length bytes special
    push_payload(8'h01);
    push_payload(8'h04);
    push_payload(8'h10);
    push_payload(8'h11);
    push_payload(8'h13);
    push_payload(8'h00);
    push_payload(8'hFF);
    push_start(8'h00, 8'h04, 8'h13, 16'h0002); // abandons the open frame
    push_payload(8'h31);
    push_payload(8'hEF);
    push_payload(8'h12);                        // after the end: ignored
    push_start(8'hA5, 8'h5A, 8'h10, 16'hFFFF);
    push_payload(8'hFF);
    push_start(8'h80, 8'h7F, 8'h04, 16'h0001);
    push_payload(8'h80);
    push_start(8'h3C, 8'hC3, 8'h00, 16'h1300);
    push_start(8'h00, 8'h00, 8'h00, 16'h0003);
    push_payload(8'hA5);
    push_payload(8'h5A);
    push_payload(8'h01);
    drain();

    write_delimiter(efb_pkg::RegStartByte, 8'h00);
    write_delimiter(efb_pkg::RegEndByte, 8'hFF);
    queue_random_frames(PhaseWords);
    drain();

    // The receiver holds off for a long stretch while words keep coming.
    write_delimiter(efb_pkg::RegStartByte, 8'hFF);
    write_delimiter(efb_pkg::RegEndByte, 8'h00);
    @(posedge clk_i);
    hold_req_cnt <= hold_req_cnt + 1;
    queue_random_frames(PhaseWords);
    drain();

    // Delimiters equal to special values go out as written.
    write_delimiter(efb_pkg::RegStartByte, 8'h10);
    write_delimiter(efb_pkg::RegEndByte, 8'h11);
    queue_random_frames(PhaseWords);
    drain();

    write_delimiter(efb_pkg::RegStartByte, 8'($urandom));
    write_delimiter(efb_pkg::RegEndByte, 8'($urandom));
    queue_random_frames(PhaseWords);
    drain();

    write_delimiter(efb_pkg::RegEndByte, efb_pkg::StartReset);
    write_delimiter(efb_pkg::RegStartByte, efb_pkg::EndReset);
    queue_random_frames(PhaseWords);
    drain();

    $display("Sent %0d start words and %0d payload words across %0d delimiter writes.",
             starts_sent, payloads_sent, delim_writes);
    $display("Compared %0d output bytes, %0d mismatches.", bytes_checked, err_cnt);
    if (err_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/efb_pkg.sv
rtl/escaped_frame_builder.sv
dv/escaped_frame_builder_tb.sv
